// ===== hw/rtl/tacf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Triangle area constraint force package
// Widths, codes and the result word type shared by the force pipeline.
// ----------------------------------------------------------------------------
package tacf_pkg;

  localparam int CW    = 32;   // vertex coordinate
  localparam int DW    = 33;   // coordinate difference
  localparam int AW    = 48;   // area field
  localparam int KW    = 32;   // stiffness register
  localparam int FW    = 48;   // force field
  localparam int CRW   = 66;   // twice-area vector component
  localparam int GW    = 99;   // gradient component
  localparam int SQW   = 132;  // sum of squares
  localparam int SHW   = 34;   // shift ahead of the square root
  localparam int SXW   = SQW - SHW;
  localparam int RTW   = 49;   // square root result
  localparam int SQTW  = SXW + 2;
  localparam int AMBW  = RTW + 1;
  localparam int MAGW  = 190;  // force numerator magnitude
  localparam int DENW  = 163;  // force denominator
  localparam int DSH   = 18;   // denominator scale
  localparam int QW    = 48;   // quotient
  localparam int DVW   = DENW + QW + 1;
  localparam int MW    = 128;  // multiplier operand
  localparam int PW    = 2 * MW;
  localparam int MCH   = 32;   // multiplier chunk
  localparam int MNC   = MW / MCH;
  localparam int MLAT  = 2;    // multiplier latency
  localparam int DLAT  = QW + 1;

  localparam logic [KW-1:0] STIFF_RST = KW'(65536);

  localparam logic [1:0] SEL_SECOND = 2'd1;
  localparam logic [1:0] SEL_THIRD  = 2'd2;

  typedef struct packed {
    logic signed [FW-1:0] force_x;
    logic signed [FW-1:0] force_y;
    logic signed [FW-1:0] force_z;
    logic [AW-1:0]        current_area;
    logic                 fault;
  } res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tacf_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Triangle area constraint force channels
// Valid/ready channels for the triangle input word and the force result word.
// ----------------------------------------------------------------------------
interface tacf_in_if import tacf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] first_x;
  logic signed [CW-1:0] first_y;
  logic signed [CW-1:0] first_z;
  logic signed [CW-1:0] second_x;
  logic signed [CW-1:0] second_y;
  logic signed [CW-1:0] second_z;
  logic signed [CW-1:0] third_x;
  logic signed [CW-1:0] third_y;
  logic signed [CW-1:0] third_z;
  logic [AW-1:0]        rest_area;
  logic [1:0]           vertex_sel;

  modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                  third_x, third_y, third_z, rest_area, vertex_sel, input ready);
  modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                third_x, third_y, third_z, rest_area, vertex_sel, output ready);
endinterface

interface tacf_out_if import tacf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [FW-1:0] force_x;
  logic signed [FW-1:0] force_y;
  logic signed [FW-1:0] force_z;
  logic [AW-1:0]        current_area;
  logic                 fault;

  modport source (output valid, force_x, force_y, force_z, current_area, fault,
                  input ready);
  modport sink (input valid, force_x, force_y, force_z, current_area, fault,
                output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/triangle_area_constraint_force_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Triangle area constraint force core
// Streams triangles and returns the area preservation force on one vertex.
// ----------------------------------------------------------------------------
// The core takes one triangle word per cycle while its skid register is empty
// and returns one result word per triangle, in order. The pipeline depth is
// set by the 49-stage square root that yields the current area and the
// 49-stage divider that scales the three force terms; the multipliers in
// between are registered as well. An output register and a skid register sit
// behind the pipeline, so the input keeps flowing while one result waits. The
// stiffness register may be written whenever the core holds no triangle.
module triangle_area_constraint_force_core import tacf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  tacf_in_if.sink          in_ch,
  tacf_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [KW-1:0]    cfg_wdata
);

  localparam int ST_IN  = 1;
  localparam int ST_C   = ST_IN + MLAT + 1;
  localparam int ST_X   = ST_C + MLAT + 1;
  localparam int ST_A   = ST_X + RTW + 1;
  localparam int ST_P   = ST_A + MLAT;
  localparam int ST_D   = ST_P + MLAT + 1;
  localparam int ST_Q   = ST_D + DLAT;
  localparam int ST_OUT = ST_Q + 1;

  logic            en;
  logic            acc;
  logic [KW-1:0]   stiff_r;
  logic            vld_r [ST_IN:ST_OUT];

  logic signed [CW-1:0] vf [3];
  logic signed [CW-1:0] vs [3];
  logic signed [CW-1:0] vt [3];
  logic signed [CW-1:0] pi [3];
  logic signed [CW-1:0] pj [3];
  logic signed [CW-1:0] pk [3];

  logic signed [DW-1:0]  ji_r [3];
  logic signed [DW-1:0]  ki_r [3];
  logic signed [DW-1:0]  e_r [ST_IN:ST_C][3];
  logic [AW-1:0]         b_r [ST_IN:ST_P];
  logic signed [CRW-1:0] c_r [3];
  logic [SXW-1:0]        x_r;
  logic signed [GW-1:0]  g_r [ST_X:ST_P][3];
  logic [RTW-1:0]        root;
  logic [RTW-1:0]        a_r;
  logic signed [AMBW-1:0] amb_r;
  logic [AW-1:0]         area_r [ST_A:ST_OUT];
  logic                  fault_r [ST_A:ST_OUT];
  logic [MAGW-1:0]       mag_r [3];
  logic                  neg_r [ST_D:ST_Q][3];
  logic [DENW-1:0]       den_r;
  logic [QW-1:0]         q [3];
  logic                  ovf [3];
  logic signed [FW-1:0]  frc_nxt [3];
  logic signed [FW-1:0]  frc_r [3];

  logic signed [PW-1:0] cp0 [3];
  logic signed [PW-1:0] cp1 [3];
  logic signed [PW-1:0] sqp [3];
  logic signed [PW-1:0] gp0 [3];
  logic signed [PW-1:0] gp1 [3];
  logic signed [PW-1:0] np [3];
  logic signed [PW-1:0] kab_p;
  logic signed [PW-1:0] ab_p;
  logic signed [PW-1:0] den_p;
  logic [SQW-1:0]       sq_sum;

  res_t res_nxt;
  res_t out_pl_r;
  res_t sk_pl_r;
  logic out_vld_r;
  logic sk_vld_r;

  assign en           = !sk_vld_r;
  assign in_ch.ready  = en;
  assign acc          = in_ch.valid && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stiff_r <= STIFF_RST;
    end else if (cfg_we) begin
      stiff_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = ST_IN; i <= ST_OUT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[ST_IN] <= acc;
      for (int i = ST_IN + 1; i <= ST_OUT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  assign vf = '{in_ch.first_x, in_ch.first_y, in_ch.first_z};
  assign vs = '{in_ch.second_x, in_ch.second_y, in_ch.second_z};
  assign vt = '{in_ch.third_x, in_ch.third_y, in_ch.third_z};

  always_comb begin
    case (in_ch.vertex_sel)
      SEL_SECOND: begin
        pi = vs;
        pj = vt;
        pk = vf;
      end
      SEL_THIRD: begin
        pi = vt;
        pj = vf;
        pk = vs;
      end
      default: begin
        pi = vf;
        pj = vs;
        pk = vt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < 3; n++) begin
        ji_r[n]        <= DW'(pj[n]) - DW'(pi[n]);
        ki_r[n]        <= DW'(pk[n]) - DW'(pi[n]);
        e_r[ST_IN][n]  <= DW'(pj[n]) - DW'(pk[n]);
      end
      b_r[ST_IN] <= in_ch.rest_area;
      for (int i = ST_IN + 1; i <= ST_C; i++) begin
        e_r[i] <= e_r[i-1];
      end
      for (int i = ST_IN + 1; i <= ST_P; i++) begin
        b_r[i] <= b_r[i-1];
      end
    end
  end

  for (genvar n = 0; n < 3; n++) begin : g_vec
    localparam int U = (n + 1) % 3;
    localparam int W = (n + 2) % 3;

    tacf_mul u_c0 (.clk, .en, .a(MW'(ji_r[U])), .b(MW'(ki_r[W])), .p(cp0[n]));
    tacf_mul u_c1 (.clk, .en, .a(MW'(ji_r[W])), .b(MW'(ki_r[U])), .p(cp1[n]));

    tacf_mul u_sq (.clk, .en, .a(MW'(c_r[n])), .b(MW'(c_r[n])), .p(sqp[n]));
    tacf_mul u_g0 (.clk, .en, .a(MW'(e_r[ST_C][U])), .b(MW'(c_r[W])), .p(gp0[n]));
    tacf_mul u_g1 (.clk, .en, .a(MW'(e_r[ST_C][W])), .b(MW'(c_r[U])), .p(gp1[n]));

    tacf_mul u_num (.clk, .en, .a(kab_p[MW-1:0]), .b(MW'(g_r[ST_P][n])), .p(np[n]));

    tacf_div u_div (.clk, .en, .mag(mag_r[n]), .den(den_r), .q(q[n]), .ovf(ovf[n]));
  end

  assign sq_sum = sqp[0][SQW-1:0] + sqp[1][SQW-1:0] + sqp[2][SQW-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < 3; n++) begin
        c_r[n]       <= CRW'(cp0[n][CRW:0] - cp1[n][CRW:0]);
        g_r[ST_X][n] <= GW'(gp0[n][GW:0] - gp1[n][GW:0]);
      end
      x_r <= sq_sum[SQW-1:SHW];
      for (int i = ST_X + 1; i <= ST_P; i++) begin
        g_r[i] <= g_r[i-1];
      end
    end
  end

  tacf_isqrt u_isqrt (.clk, .en, .x(x_r), .root(root));

  always_ff @(posedge clk) begin
    if (en) begin
      a_r              <= root;
      amb_r            <= AMBW'(root) - AMBW'(b_r[ST_A-1]);
      area_r[ST_A]     <= root[RTW-1] ? '1 : root[AW-1:0];
      fault_r[ST_A]    <= (root == '0) || (b_r[ST_A-1] == '0);
      for (int i = ST_A + 1; i <= ST_OUT; i++) begin
        area_r[i]  <= area_r[i-1];
        fault_r[i] <= fault_r[i-1];
      end
    end
  end

  tacf_mul u_kab (.clk, .en, .a(MW'(stiff_r)), .b(MW'(amb_r)), .p(kab_p));
  tacf_mul u_ab (.clk, .en, .a(MW'(a_r)), .b(MW'(b_r[ST_A])), .p(ab_p));
  tacf_mul u_den (.clk, .en, .a(ab_p[MW-1:0]), .b(MW'(b_r[ST_P])), .p(den_p));

  always_ff @(posedge clk) begin
    if (en) begin
      den_r <= {den_p[DENW-DSH-1:0], {DSH{1'b0}}};
      for (int n = 0; n < 3; n++) begin
        neg_r[ST_D][n] <= !np[n][PW-1] && (np[n] != '0);
        mag_r[n]       <= np[n][PW-1] ? MAGW'(-np[n]) : MAGW'(np[n]);
      end
      for (int i = ST_D + 1; i <= ST_Q; i++) begin
        neg_r[i] <= neg_r[i-1];
      end
    end
  end

  always_comb begin
    logic [QW-1:0] lim;
    logic [QW-1:0] mv;
    for (int n = 0; n < 3; n++) begin
      lim = neg_r[ST_Q][n] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
      mv  = (ovf[n] || (q[n] > lim)) ? lim : q[n];
      frc_nxt[n] = neg_r[ST_Q][n] ? $signed(-mv) : $signed(mv);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      frc_r <= frc_nxt;
    end
  end

  always_comb begin
    res_nxt.force_x      = fault_r[ST_OUT] ? '0 : frc_r[0];
    res_nxt.force_y      = fault_r[ST_OUT] ? '0 : frc_r[1];
    res_nxt.force_z      = fault_r[ST_OUT] ? '0 : frc_r[2];
    res_nxt.current_area = area_r[ST_OUT];
    res_nxt.fault        = fault_r[ST_OUT];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      sk_vld_r  <= 1'b0;
    end else if (!out_vld_r || out_ch.ready) begin
      if (sk_vld_r) begin
        out_vld_r <= 1'b1;
        sk_vld_r  <= 1'b0;
      end else begin
        out_vld_r <= en && vld_r[ST_OUT];
      end
    end else if (en && vld_r[ST_OUT]) begin
      sk_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || out_ch.ready) begin
      out_pl_r <= sk_vld_r ? sk_pl_r : res_nxt;
    end else if (en && vld_r[ST_OUT]) begin
      sk_pl_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.force_x      = out_pl_r.force_x;
  assign out_ch.force_y      = out_pl_r.force_y;
  assign out_ch.force_z      = out_pl_r.force_z;
  assign out_ch.current_area = out_pl_r.current_area;
  assign out_ch.fault        = out_pl_r.fault;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    sk_vld_r |-> out_vld_r)
    else $error("Skid word held while the output register is empty.");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_pl_r.fault) |->
      (out_pl_r.force_x == '0 && out_pl_r.force_y == '0 && out_pl_r.force_z == '0))
    else $error("Faulted word carries a nonzero force.");

  a_area_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_pl_r.fault) |-> (out_pl_r.current_area != '0))
    else $error("Word without fault reports a zero area.");

endmodule
`default_nettype wire

// ===== hw/rtl/tacf_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined signed multiplier
// Two stages: 32 by 32 bit partial products, then their shifted sum.
// ----------------------------------------------------------------------------
module tacf_mul import tacf_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [MW-1:0] a,
  input  logic signed [MW-1:0] b,
  output logic signed [PW-1:0] p
);

  logic signed [MCH:0]     ach [MNC];
  logic signed [MCH:0]     bch [MNC];
  logic signed [2*MCH+1:0] pp_nxt [MNC][MNC];
  logic signed [2*MCH+1:0] pp_r [MNC][MNC];
  logic signed [PW-1:0]    p_nxt;
  logic signed [PW-1:0]    p_r;

  always_comb begin
    for (int i = 0; i < MNC; i++) begin
      if (i == MNC - 1) begin
        ach[i] = $signed({a[MW-1], a[MCH*i +: MCH]});
        bch[i] = $signed({b[MW-1], b[MCH*i +: MCH]});
      end else begin
        ach[i] = $signed({1'b0, a[MCH*i +: MCH]});
        bch[i] = $signed({1'b0, b[MCH*i +: MCH]});
      end
    end
    for (int i = 0; i < MNC; i++) begin
      for (int j = 0; j < MNC; j++) begin
        pp_nxt[i][j] = ach[i] * bch[j];
      end
    end
  end

  always_comb begin
    p_nxt = '0;
    for (int i = 0; i < MNC; i++) begin
      for (int j = 0; j < MNC; j++) begin
        p_nxt = p_nxt + (PW'(pp_r[i][j]) <<< (MCH * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_r <= pp_nxt;
      p_r  <= p_nxt;
    end
  end

  assign p = p_r;

endmodule
`default_nettype wire

// ===== hw/rtl/tacf_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One result bit per stage, restoring digit-by-digit method.
// ----------------------------------------------------------------------------
module tacf_isqrt import tacf_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  logic [SXW-1:0]  x,
  output logic [RTW-1:0]  root
);

  logic [SQTW-1:0] rem_r [RTW-1];
  logic [RTW-1:0]  root_r [RTW];

  for (genvar k = 0; k < RTW; k++) begin : g_st
    localparam int B = RTW - 1 - k;
    logic [SQTW-1:0] rin;
    logic [RTW-1:0]  qin;
    logic [SQTW-1:0] trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign rin = SQTW'(x);
      assign qin = '0;
    end else begin : g_next
      assign rin = rem_r[k-1];
      assign qin = root_r[k-1];
    end

    assign trial = (SQTW'(qin) << (B + 1)) | (SQTW'(1) << (2 * B));
    assign ge    = rin >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= qin | (RTW'(ge) << B);
      end
    end

    if (k < RTW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? rin - trial : rin;
        end
      end
    end
  end

  assign root = root_r[RTW-1];

endmodule
`default_nettype wire

// ===== hw/rtl/tacf_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined force divider
// Overflow check, then one restoring quotient bit per stage.
// ----------------------------------------------------------------------------
module tacf_div import tacf_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  logic [MAGW-1:0] mag,
  input  logic [DENW-1:0] den,
  output logic [QW-1:0]   q,
  output logic            ovf
);

  logic [DVW-1:0]  rem_r [QW];
  logic [DENW-1:0] den_r [QW];
  logic [QW-1:0]   q_r [QW+1];
  logic            ovf_r [QW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= DVW'(mag);
      den_r[0] <= den;
      q_r[0]   <= '0;
      ovf_r[0] <= DVW'(mag) >= (DVW'(den) << QW);
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_st
    localparam int B = QW - k;
    logic [DVW-1:0] trial;
    logic           ge;

    assign trial = DVW'(den_r[k-1]) << B;
    assign ge    = rem_r[k-1] >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k]   <= q_r[k-1] | (QW'(ge) << B);
        ovf_r[k] <= ovf_r[k-1];
      end
    end

    if (k < QW) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? rem_r[k-1] - trial : rem_r[k-1];
          den_r[k] <= den_r[k-1];
        end
      end
    end
  end

  assign q   = q_r[QW];
  assign ovf = ovf_r[QW];

endmodule
`default_nettype wire

// ===== tb/tb_triangle_area_constraint_force_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle area constraint force core testbench
// Streams directed and random triangles through the core under random input
// gaps and output stalls, across several stiffness settings. Each result word
// is checked in order against an exact wide integer model or a preset word.
// ----------------------------------------------------------------------------
module tb_triangle_area_constraint_force_core;
  import tacf_pkg::*;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic signed [CW-1:0] coord[9];
    logic [AW-1:0]        rest;
    logic [1:0]           sel;
  } tri_t;

  typedef struct {
    tri_t tri_in;
    bit   typed;
    res_t res;
  } row_t;

  localparam logic [63:0] AREA_MAX = 64'hFFFF_FFFF_FFFF;
  localparam int          DRAIN    = 150;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [KW-1:0] cfg_wdata;

  tacf_in_if  in_if ();
  tacf_out_if out_if ();

  triangle_area_constraint_force_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  logic [KW-1:0] stiffness;
  res_t          force_fifo[$];
  int            mismatches;
  bit            no_idle;
  int            stall_left;
  row_t          rows[$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  function automatic res_t predict_force(tri_t t, logic [KW-1:0] k);
    longint p[3][3];
    longint ji[3], ki[3], e[3];
    int     s;
    wide_t  cx, cy, cz, sq, tt, kab, den, num, mag, q;
    wide_t  g[3];
    logic [63:0] a, v, lim;
    bit     neg;
    res_t   r;
    for (int i = 0; i < 3; i++) begin
      for (int n = 0; n < 3; n++) begin
        p[i][n] = t.coord[i*3+n];
      end
    end
    s = (t.sel == 2'd3) ? 0 : int'(t.sel);
    for (int n = 0; n < 3; n++) begin
      ji[n] = p[(s+1)%3][n] - p[s][n];
      ki[n] = p[(s+2)%3][n] - p[s][n];
      e[n]  = p[(s+1)%3][n] - p[(s+2)%3][n];
    end
    cx = wide_t'(ji[1]) * wide_t'(ki[2]) - wide_t'(ji[2]) * wide_t'(ki[1]);
    cy = wide_t'(ji[2]) * wide_t'(ki[0]) - wide_t'(ji[0]) * wide_t'(ki[2]);
    cz = wide_t'(ji[0]) * wide_t'(ki[1]) - wide_t'(ji[1]) * wide_t'(ki[0]);
    sq = (cx * cx + cy * cy + cz * cz) >>> 34;
    a = 0;
    for (int b = 55; b >= 0; b--) begin
      v = a | (64'd1 << b);
      tt = wide_t'(v);
      if (tt * tt <= sq) a = v;
    end
    r.current_area = (a > AREA_MAX) ? AW'(AREA_MAX) : a[AW-1:0];
    r.force_x = '0;
    r.force_y = '0;
    r.force_z = '0;
    r.fault = 1'b1;
    if (a == 0 || t.rest == 0) return r;
    r.fault = 1'b0;
    kab = wide_t'(k) * (wide_t'(a) - wide_t'(t.rest));
    den = wide_t'(a) * wide_t'(t.rest) * wide_t'(t.rest) * (wide_t'(1) <<< DSH);
    g[0] = wide_t'(e[1]) * cz - wide_t'(e[2]) * cy;
    g[1] = wide_t'(e[2]) * cx - wide_t'(e[0]) * cz;
    g[2] = wide_t'(e[0]) * cy - wide_t'(e[1]) * cx;
    for (int n = 0; n < 3; n++) begin
      num = -(kab * g[n]);
      neg = num < 0;
      mag = neg ? -num : num;
      q = mag / den;
      lim = neg ? (64'd1 << 47) : ((64'd1 << 47) - 1);
      v = (q > wide_t'(lim)) ? lim : q[63:0];
      if (neg) v = -v;
      if (n == 0) r.force_x = v[FW-1:0];
      else if (n == 1) r.force_y = v[FW-1:0];
      else r.force_z = v[FW-1:0];
    end
    return r;
  endfunction

  function automatic tri_t make_tri(longint c[9], logic [AW-1:0] rest, logic [1:0] sel);
    tri_t t;
    for (int i = 0; i < 9; i++) t.coord[i] = c[i][CW-1:0];
    t.rest = rest;
    t.sel = sel;
    return t;
  endfunction

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return CW'($signed($urandom_range(0, 2**20)) - 2**19);
      2: return CW'($signed($urandom_range(0, 2**26)) - 2**25);
      default: return CW'($signed($urandom_range(0, 2**14)) - 2**13);
    endcase
  endfunction

  function automatic tri_t rand_tri();
    tri_t t;
    res_t r;
    logic [AW-1:0] d;
    for (int i = 0; i < 9; i++) t.coord[i] = rand_coord();
    t.sel = 2'($urandom_range(0, 3));
    t.rest = 1;
    r = predict_force(t, stiffness);
    d = AW'($urandom_range(0, 4096));
    case ($urandom_range(0, 9))
      0: t.rest = '0;
      1, 2: t.rest = AW'({$urandom, $urandom});
      3: t.rest = AW'($urandom_range(1, 255));
      default: t.rest = ($urandom_range(0, 1) || r.current_area <= d) ?
                        r.current_area + d : r.current_area - d;
    endcase
    return t;
  endfunction

  task automatic send_triangle(row_t row);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.first_x    <= row.tri_in.coord[0];
    in_if.first_y    <= row.tri_in.coord[1];
    in_if.first_z    <= row.tri_in.coord[2];
    in_if.second_x   <= row.tri_in.coord[3];
    in_if.second_y   <= row.tri_in.coord[4];
    in_if.second_z   <= row.tri_in.coord[5];
    in_if.third_x    <= row.tri_in.coord[6];
    in_if.third_y    <= row.tri_in.coord[7];
    in_if.third_z    <= row.tri_in.coord[8];
    in_if.rest_area  <= row.tri_in.rest;
    in_if.vertex_sel <= row.tri_in.sel;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    force_fifo.push_back(row.typed ? row.res : predict_force(row.tri_in, stiffness));
  endtask

  task automatic write_stiffness(logic [KW-1:0] value);
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (force_fifo.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    stiffness = value;
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(int count);
    row_t row;
    row.typed = 1'b0;
    for (int i = 0; i < count; i++) begin
      row.tri_in = rand_tri();
      send_triangle(row);
    end
  endtask

  always @(posedge clk) begin
    res_t exp_res;
    if (out_if.valid && out_if.ready) begin
      if (force_fifo.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word at %0t", $realtime);
      end else begin
        exp_res = force_fifo.pop_front();
        if (out_if.force_x !== exp_res.force_x || out_if.force_y !== exp_res.force_y ||
            out_if.force_z !== exp_res.force_z ||
            out_if.current_area !== exp_res.current_area || out_if.fault !== exp_res.fault) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch at %0t: expected f=(%0d,%0d,%0d) a=%0d fault=%0b",
                     $realtime, exp_res.force_x, exp_res.force_y, exp_res.force_z,
                     exp_res.current_area, exp_res.fault);
            $display("  actual f=(%0d,%0d,%0d) a=%0d fault=%0b", out_if.force_x,
                     out_if.force_y, out_if.force_z, out_if.current_area, out_if.fault);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    logic rdy;
    rdy = 1'b1;
    if (no_idle) begin
      stall_left <= 0;
    end else if (stall_left > 0) begin
      rdy = 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      rdy = 1'b0;
      stall_left <= $urandom_range(0, 5);
    end
    out_if.ready <= rdy;
  end

  initial begin
    longint big;
    longint sm;
    row_t   row;
    mismatches = 0;
    no_idle = 1'b0;
    stall_left = 0;
    stiffness = STIFF_RST;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    out_if.ready = 1'b0;
    in_if.valid = 1'b0;
    in_if.first_x = '0;
    in_if.first_y = '0;
    in_if.first_z = '0;
    in_if.second_x = '0;
    in_if.second_y = '0;
    in_if.second_z = '0;
    in_if.third_x = '0;
    in_if.third_y = '0;
    in_if.third_z = '0;
    in_if.rest_area = '0;
    in_if.vertex_sel = '0;
    big = 64'sh7FFF_FFFF;
    sm = -64'sh8000_0000;

    row.typed = 1'b1;
    row.res = '{force_x: '0, force_y: '0, force_z: '0, current_area: '0, fault: 1'b1};
    row.tri_in = make_tri('{0, 0, 0, 0, 0, 0, 0, 0, 0}, 48'd65536, 2'd0);
    rows.push_back(row);
    row.tri_in = make_tri('{0, 0, 0, 0, 0, 0, 0, 0, 0}, '0, 2'd3);
    rows.push_back(row);
    row.tri_in = make_tri('{big, big, big, big, big, big, big, big, big}, '1, 2'd1);
    rows.push_back(row);
    row.res = '{force_x: '0, force_y: '0, force_z: '0, current_area: 48'd32768, fault: 1'b0};
    for (int s = 0; s < 4; s++) begin
      row.tri_in = make_tri('{0, 0, 0, 65536, 0, 0, 0, 65536, 0}, 48'd32768, 2'(s));
      rows.push_back(row);
    end
    row.typed = 1'b0;
    for (int s = 0; s < 4; s++) begin
      row.tri_in = make_tri('{0, 0, 0, 65536, 0, 0, 0, 65536, 0}, 48'd1, 2'(s));
      rows.push_back(row);
      row.tri_in = make_tri('{sm, sm, sm, big, sm, big, sm, big, sm}, 48'd1, 2'(s));
      rows.push_back(row);
    end
    row.tri_in = make_tri('{0, 0, 0, 65536, 0, 0, 0, 65536, 0}, '1, 2'd2);
    rows.push_back(row);
    row.tri_in = make_tri('{sm, sm, sm, big, big, big, sm, big, sm}, '1, 2'd0);
    rows.push_back(row);
    row.tri_in = make_tri('{big, 0, sm, sm, big, 0, 0, sm, big}, '0, 2'd1);
    rows.push_back(row);
    row.tri_in = make_tri('{0, 0, 0, 1, 0, 0, 0, 1, 0}, 48'd100, 2'd2);
    rows.push_back(row);
    row.tri_in = make_tri('{5, -7, 3, 900, 13, -2, -40, 700, 11}, 48'd3, 2'd1);
    rows.push_back(row);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_triangle(rows[i]);
    run_random(140);
    write_stiffness('0);
    run_random(130);
    write_stiffness('1);
    run_random(130);
    write_stiffness($urandom);
    run_random(130);
    write_stiffness(32'd1);
    run_random(130);
    write_stiffness(STIFF_RST);
    run_random(60);
    no_idle = 1'b1;
    run_random(80);
    in_if.valid <= 1'b0;

    while (force_fifo.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0 && force_fifo.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
